// File: hdl/cwa_pkg.sv
package cwa_pkg;

  localparam int IDX_W          = 10;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int POINTS_LOG2_W  = 4;

  localparam logic [POINTS_LOG2_W-1:0] POINTS_LOG2_RESET = 4'd11;

  typedef enum logic [0:0] {
    REG_POINTS_LOG2 = 1'b0
  } cfg_reg_t;

  typedef struct packed {
    logic             emit_reg;
    logic             emit_wrap;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_wrap;
  } job_ctrl_t;

endpackage

// File: hdl/chaikin_wavelet_analysis_step.sv
// One analysis level of a closed-curve Chaikin wavelet over 3-D points.
// Slave stream: one curve point per beat, x/y/z packed in s_tdata.
// Master stream: one coarse/detail pair per beat; m_tlast marks the
// wrapping final pair of the level.
// APB register points_log2 (address 0) sets n = 2^points_log2 points per
// level; write it only while the block is idle.
// Throughput: one point per cycle while s_tready is high. A point with an
// odd index >= 3 yields one pair; the last point of a level yields up to two
// pairs back to back. A pair reaches m_tvalid through the window register
// (taps and job flags), then the result queue, which the adders write.
// A four-entry result queue parts the two sides; s_tready drops only when
// results in flight could overfill it, so a stalled receiver holds all
// pairs and the slave side backs up after at most a few beats.
// Reset clears the point counter, the queue and sets points_log2 to 11.
module chaikin_wavelet_analysis_step
  import cwa_pkg::*;
#(
  parameter int MAX_POINTS_LOG2 = 11,
  parameter int COORD_WIDTH     = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  // APB
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // points in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // point_x, point_y, point_z
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  // pairs out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // coarse_x, coarse_y, coarse_z, detail_x, detail_y, detail_z, pair_index
  output logic [((6*(COORD_WIDTH+3)+IDX_W+7)/8)*8-1:0] m_tdata,
  // level_done
  output logic                  m_tlast
);

  localparam int PW      = 3 * COORD_WIDTH;
  localparam int RW      = COORD_WIDTH + 3;
  localparam int PAY_W   = 6 * RW + IDX_W;
  localparam int EW      = PAY_W + 1;
  localparam int OUT_W   = ((PAY_W + 7) / 8) * 8;
  localparam int CNT_W   = MAX_POINTS_LOG2;
  localparam int LG_W    = $clog2(MAX_POINTS_LOG2 + 1);
  localparam logic [CNT_W-1:0] ALL_ONES = '1;
  localparam logic [CNT_W-1:0] CNT_ONE  = 1;

  // configuration
  logic [POINTS_LOG2_W-1:0] points_log2;
  logic                     cfg_wr;
  logic                     cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (cfg_reg_t'(paddr[CFG_ADDR_W-1]) == REG_POINTS_LOG2);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (cfg_sel) begin
      prdata = CFG_DATA_W'(points_log2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_log2 <= POINTS_LOG2_RESET;
    end else if (cfg_wr && cfg_sel) begin
      points_log2 <= pwdata[POINTS_LOG2_W-1:0];
    end
  end

  // level size
  logic [LG_W-1:0]  lg_eff;
  logic [CNT_W-1:0] last_idx;

  always_comb begin
    if (points_log2 == '0) begin
      lg_eff = LG_W'(1);
    end else if (int'(points_log2) > MAX_POINTS_LOG2) begin
      lg_eff = LG_W'(MAX_POINTS_LOG2);
    end else begin
      lg_eff = LG_W'(points_log2);
    end
    last_idx = ALL_ONES >> (LG_W'(MAX_POINTS_LOG2) - lg_eff);
  end

  // point counter and handshake
  logic [CNT_W-1:0] point_counter;
  logic [CNT_W-1:0] point_counter_next;
  logic             accept;
  logic             is_last;
  logic             is_odd_pair;
  job_ctrl_t        job;
  job_ctrl_t        job_next;
  logic [2:0]       fifo_count;
  logic [3:0]       fill_sum;

  assign is_last     = (point_counter >= last_idx);
  assign is_odd_pair = (point_counter >= 3) && point_counter[0];
  assign accept      = s_tvalid && s_tready;

  always_comb begin
    fill_sum = 4'(fifo_count) + 4'(job.emit_reg) + 4'(job.emit_wrap)
             + 4'(is_odd_pair) + 4'(is_last);
    s_tready = (fill_sum <= 4'd4);
  end

  always_comb begin
    point_counter_next = is_last ? '0 : point_counter + CNT_ONE;
    job_next.emit_reg  = accept && is_odd_pair;
    job_next.emit_wrap = accept && is_last;
    job_next.idx_reg   = IDX_W'((point_counter >> 1) - CNT_ONE);
    job_next.idx_wrap  = IDX_W'(last_idx >> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_counter <= '0;
      job           <= '0;
    end else begin
      job <= job_next;
      if (accept) begin
        point_counter <= point_counter_next;
      end
    end
  end

  // window taps (tap[3] newest) and first two points of the level
  logic [PW-1:0] tap [4];
  logic [PW-1:0] first0;
  logic [PW-1:0] first1;

  always_ff @(posedge clk) begin
    if (accept) begin
      tap[0] <= tap[1];
      tap[1] <= tap[2];
      tap[2] <= tap[3];
      tap[3] <= s_tdata[PW-1:0];
      if (point_counter == '0) begin
        first0 <= s_tdata[PW-1:0];
      end
      if (point_counter == CNT_ONE) begin
        first1 <= s_tdata[PW-1:0];
      end
    end
  end

  // pair arithmetic
  logic [3*RW-1:0] reg_coarse;
  logic [3*RW-1:0] reg_detail;
  logic [3*RW-1:0] wrap_coarse;
  logic [3*RW-1:0] wrap_detail;

  cwa_pair_calc #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_calc_reg (
    .c0    (tap[0]),
    .c1    (tap[1]),
    .c2    (tap[2]),
    .c3    (tap[3]),
    .coarse(reg_coarse),
    .detail(reg_detail)
  );

  cwa_pair_calc #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_calc_wrap (
    .c0    (tap[2]),
    .c1    (tap[3]),
    .c2    (first0),
    .c3    (first1),
    .coarse(wrap_coarse),
    .detail(wrap_detail)
  );

  logic [EW-1:0] reg_word;
  logic [EW-1:0] wrap_word;
  logic [EW-1:0] wdata0;
  logic          wr0;
  logic          wr1;
  logic [EW-1:0] head;

  assign reg_word  = {1'b0, job.idx_reg, reg_detail, reg_coarse};
  assign wrap_word = {1'b1, job.idx_wrap, wrap_detail, wrap_coarse};
  assign wr0       = job.emit_reg || job.emit_wrap;
  assign wr1       = job.emit_reg && job.emit_wrap;
  assign wdata0    = job.emit_reg ? reg_word : wrap_word;

  cwa_result_fifo #(
    .WIDTH(EW)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr0   (wr0),
    .wdata0(wdata0),
    .wr1   (wr1),
    .wdata1(wrap_word),
    .rd    (m_tready),
    .rdata (head),
    .valid (m_tvalid),
    .count (fifo_count)
  );

  assign m_tdata = OUT_W'(head[PAY_W-1:0]);
  assign m_tlast = head[EW-1];

endmodule

// File: hdl/cwa_pair_calc.sv
module cwa_pair_calc #(
  parameter int COORD_WIDTH = 24
) (
  input  logic [3*COORD_WIDTH-1:0]     c0,
  input  logic [3*COORD_WIDTH-1:0]     c1,
  input  logic [3*COORD_WIDTH-1:0]     c2,
  input  logic [3*COORD_WIDTH-1:0]     c3,
  output logic [3*(COORD_WIDTH+3)-1:0] coarse,
  output logic [3*(COORD_WIDTH+3)-1:0] detail
);

  localparam int RW = COORD_WIDTH + 3;

  // coarse = 3(c1+c2) - (c0+c3), detail = 3(c2-c1) + (c0-c3), exact in RW bits
  always_comb begin
    logic signed [RW-1:0] a0, a1, a2, a3;
    logic signed [RW-1:0] s12, d21, s03, d03;
    for (int k = 0; k < 3; k++) begin
      a0  = RW'($signed(c0[k*COORD_WIDTH +: COORD_WIDTH]));
      a1  = RW'($signed(c1[k*COORD_WIDTH +: COORD_WIDTH]));
      a2  = RW'($signed(c2[k*COORD_WIDTH +: COORD_WIDTH]));
      a3  = RW'($signed(c3[k*COORD_WIDTH +: COORD_WIDTH]));
      s12 = a1 + a2;
      d21 = a2 - a1;
      s03 = a0 + a3;
      d03 = a0 - a3;
      coarse[k*RW +: RW] = (s12 <<< 1) + s12 - s03;
      detail[k*RW +: RW] = (d21 <<< 1) + d21 + d03;
    end
  end

endmodule

// File: hdl/cwa_result_fifo.sv
module cwa_result_fifo #(
  parameter int WIDTH = 173
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr0,
  input  logic [WIDTH-1:0] wdata0,
  input  logic             wr1,
  input  logic [WIDTH-1:0] wdata1,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             valid,
  output logic [2:0]       count
);

  logic [WIDTH-1:0] entry [4];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [1:0]       wr_ptr_next;
  logic [2:0]       count_next;
  logic             pop;

  assign pop   = rd && valid;
  assign valid = (count != 3'd0);
  assign rdata = entry[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr + 2'(wr0) + 2'(wr1);
    count_next  = count + 3'(wr0) + 3'(wr1) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (wr0) begin
      entry[wr_ptr] <= wdata0;
    end
    if (wr1) begin
      entry[wr_ptr + 2'd1] <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
    end
  end

endmodule
